### rtl/core/grrna_pkg.sv
// ----------------------------------------------------------------------------
// grrna_pkg
// Shared constants, codes and controller/datapath interface types of the
// group round-robin node allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package grrna_pkg;

  // Machine size limits.
  localparam int MAX_GROUPS      = 16;
  localparam int MAX_GROUP_NODES = 16;
  localparam int MAX_JOB         = 64;
  localparam int NODE_SLOTS      = MAX_GROUPS * MAX_GROUP_NODES;

  // Field and register widths.
  localparam int NODE_W    = 8;
  localparam int SIZE_W    = 7;
  localparam int CFG_W     = 5;
  localparam int CFG_IDX_W = 1;

  // The free map is stored as rows of node bits.
  localparam int ROW_BITS = 16;
  localparam int ROWS     = NODE_SLOTS / ROW_BITS;
  localparam int ROW_W    = $clog2(ROWS);
  localparam int COL_W    = $clog2(ROW_BITS);

  // Scan pointers and counters.
  localparam int GP_W  = $clog2(MAX_GROUPS);
  localparam int LP_W  = $clog2(MAX_GROUP_NODES) + 1;
  localparam int CNT_W = $clog2(NODE_SLOTS) + 1;

  // Operation codes.
  localparam logic OP_SET   = 1'b0;
  localparam logic OP_ALLOC = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_GROUPS      = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_NODES_PER_GROUP = 1'b1;

  // Controller states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_UPD_RD,
    S_UPD_WR,
    S_DECIDE,
    S_CNT_RD,
    S_CNT_ACC,
    S_CNT_CHK,
    S_FAIL,
    S_ENTER,
    S_PROBE,
    S_CHECK
  } ctrl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic upd_rd;
    logic upd_wr;
    logic cnt_rd;
    logic cnt_acc;
    logic scan_init;
    logic enter;
    logic skip_group;
    logic next_node;
    logic pick;
    logic fail;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic size_zero;
    logic size_big;
    logic cnt_last;
    logic too_few;
    logic grp_done;
    logic node_free;
    logic job_last;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

### rtl/core/group_round_robin_node_allocator.sv
// ----------------------------------------------------------------------------
// group_round_robin_node_allocator
// Keeps a free map of up to 256 nodes and hands out node indices for jobs,
// rotating over groups of nodes.
// ----------------------------------------------------------------------------
// One transaction is handled at a time. A status update (op 0) is a
// read-modify-write of one 16-node row of the free-map memory, and gives no
// result. A job request (op 1) first counts the free nodes of the machine by
// sweeping the 16 rows of the free map. A job with too few free nodes then
// gives a failure result, and a job that fits goes on to the scan. An
// oversized job gives its failure result without the count, and an empty
// job frees the block without a result. The scan enters each group in turn,
// probes its nodes with one memory read per probe, and passes on a group in
// which no usable node is left. Each pick waits while the previous result is
// stalled in the output register. A result that waits in the output register
// does not keep the block from taking the next request. Reset leaves every
// node free.
// ----------------------------------------------------------------------------
`default_nettype none

module group_round_robin_node_allocator import grrna_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // Configuration port.
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i,
  // Request channel.
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic                 op_i,
  input  wire logic [NODE_W-1:0]    node_i,
  input  wire logic                 is_free_i,
  input  wire logic [SIZE_W-1:0]    job_size_i,
  // Result channel.
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic      [NODE_W-1:0]    node_index_o,
  output logic                      ok_o,
  output logic                      last_o
);

  dp_cmd_t    cmd;
  dp_status_t status;

  grrna_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .op_i      (op_i),
    .in_ready_o(in_ready_o),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  grrna_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .node_i      (node_i),
    .is_free_i   (is_free_i),
    .job_size_i  (job_size_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .node_index_o(node_index_o),
    .ok_o        (ok_o),
    .last_o      (last_o)
  );

  // A failure result always closes its job.
  a_fail_is_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !ok_o |-> last_o)
    else $error("failure result without last");

  // A failure result carries node zero.
  a_fail_node_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !ok_o |-> node_index_o == '0)
    else $error("failure result with nonzero node");

  // A status update keeps the block busy for its write-back.
  a_update_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && op_i == OP_SET |=> !in_ready_o)
    else $error("request taken during a status update");

endmodule

`default_nettype wire

### rtl/core/grrna_ram.sv
// ----------------------------------------------------------------------------
// grrna_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module grrna_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### rtl/core/grrna_dp.sv
// ----------------------------------------------------------------------------
// grrna_dp
// Datapath of the node allocator: configuration registers, the free-map
// memory, the free-node counter, the round-robin scan pointers and the
// result register.
// ----------------------------------------------------------------------------
`default_nettype none

module grrna_dp import grrna_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // Configuration writes.
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i,
  // Input transaction payload.
  input  wire logic [NODE_W-1:0]    node_i,
  input  wire logic                 is_free_i,
  input  wire logic [SIZE_W-1:0]    job_size_i,
  // Controller interface.
  input  wire dp_cmd_t              cmd_i,
  output dp_status_t                status_o,
  // Result channel.
  input  wire logic                 out_ready_i,
  output logic                      out_valid_o,
  output logic      [NODE_W-1:0]    node_index_o,
  output logic                      ok_o,
  output logic                      last_o
);

  // Clamp a configuration value to the range 1 .. hi.
  function automatic logic [CFG_W-1:0] clamp_cfg(logic [CFG_W-1:0] v, logic [CFG_W-1:0] hi);
    logic [CFG_W-1:0] r;
    if (v == '0) begin
      r = CFG_W'(1);
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

  logic [CFG_W-1:0]    num_groups_q, nodes_per_group_q;
  logic [CFG_W-1:0]    g_eff, p_eff;
  logic [CNT_W-1:0]    limit;

  logic [NODE_W-1:0]   node_q;
  logic                is_free_q;
  logic [SIZE_W-1:0]   size_q;

  logic [ROWS-1:0]     row_valid_q;
  logic [ROW_W-1:0]    rd_row_q;
  logic [ROW_W-1:0]    raddr;
  logic [ROW_BITS-1:0] rdata, row_eff, wdata;

  logic [ROW_W-1:0]    row_q;
  logic [CNT_W-1:0]    acc_q;
  logic [COL_W:0]      pop;

  logic [GP_W-1:0]     gp_q, gp_next;
  logic [CFG_W-1:0]    gp_inc;
  logic [LP_W-1:0]     lp_q;
  logic [LP_W-1:0]     resume_q [MAX_GROUPS];
  logic [SIZE_W-1:0]   picks_q;
  logic [CNT_W-1:0]    idx_full;
  logic [NODE_W-1:0]   idx;

  logic                out_valid_q, ok_q, last_q;
  logic [NODE_W-1:0]   node_index_q;
  logic                out_load;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_groups_q      <= CFG_W'(MAX_GROUPS);
      nodes_per_group_q <= CFG_W'(MAX_GROUP_NODES);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_NUM_GROUPS:      num_groups_q      <= cfg_data_i;
        CFG_NODES_PER_GROUP: nodes_per_group_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Effective machine shape and node index of the scan position.
  assign g_eff    = clamp_cfg(num_groups_q, CFG_W'(MAX_GROUPS));
  assign p_eff    = clamp_cfg(nodes_per_group_q, CFG_W'(MAX_GROUP_NODES));
  assign limit    = CNT_W'({{(CNT_W-CFG_W){1'b0}}, g_eff} * {{(CNT_W-CFG_W){1'b0}}, p_eff});
  assign idx_full = CNT_W'({{(CNT_W-GP_W){1'b0}}, gp_q} * {{(CNT_W-CFG_W){1'b0}}, p_eff})
                  + {{(CNT_W-LP_W){1'b0}}, lp_q};
  assign idx      = idx_full[NODE_W-1:0];

  // Captured request fields.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      node_q    <= node_i;
      is_free_q <= is_free_i;
      size_q    <= job_size_i;
    end
  end

  // Free-map read address: status update, counting sweep, or scan probe.
  always_comb begin
    if (cmd_i.upd_rd) begin
      raddr = node_q[NODE_W-1:COL_W];
    end else if (cmd_i.cnt_rd) begin
      raddr = row_q;
    end else begin
      raddr = idx[NODE_W-1:COL_W];
    end
  end

  grrna_ram #(
    .WIDTH(ROW_BITS),
    .DEPTH(ROWS)
  ) u_free_map (
    .clk_i  (clk_i),
    .we_i   (cmd_i.upd_wr),
    .waddr_i(node_q[NODE_W-1:COL_W]),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // A row that was never written holds all nodes free.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_valid_q <= '0;
    end else if (cmd_i.upd_wr) begin
      row_valid_q[node_q[NODE_W-1:COL_W]] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_row_q <= raddr;
  end

  assign row_eff = row_valid_q[rd_row_q] ? rdata : '1;

  // Read-modify-write of one node's free bit.
  always_comb begin
    wdata = row_eff;
    wdata[node_q[COL_W-1:0]] = is_free_q;
  end

  // Free nodes of the current row that lie inside the machine.
  always_comb begin
    pop = '0;
    for (int b = 0; b < ROW_BITS; b++) begin
      if ({1'b0, row_q, COL_W'(b)} < limit) begin
        pop = pop + (COL_W + 1)'(row_eff[b]);
      end
    end
  end

  // Counting sweep over the rows.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      row_q <= '0;
      acc_q <= '0;
    end else if (cmd_i.cnt_acc) begin
      row_q <= row_q + ROW_W'(1);
      acc_q <= acc_q + CNT_W'(pop);
    end
  end

  // Next group, wrapping at the number of groups.
  assign gp_inc  = CFG_W'(gp_q) + CFG_W'(1);
  assign gp_next = (gp_inc < g_eff) ? gp_inc[GP_W-1:0] : '0;

  // Round-robin scan pointers. Each group remembers where its scan stopped,
  // since the picked nodes of a group are always its first free nodes.
  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_init) begin
      gp_q    <= '0;
      picks_q <= '0;
      for (int i = 0; i < MAX_GROUPS; i++) begin
        resume_q[i] <= '0;
      end
    end else if (cmd_i.enter) begin
      lp_q <= resume_q[gp_q];
    end else if (cmd_i.skip_group) begin
      resume_q[gp_q] <= lp_q;
      gp_q           <= gp_next;
    end else if (cmd_i.next_node) begin
      lp_q <= lp_q + LP_W'(1);
    end else if (cmd_i.pick) begin
      resume_q[gp_q] <= lp_q + LP_W'(1);
      gp_q           <= gp_next;
      picks_q        <= picks_q + SIZE_W'(1);
    end
  end

  // Result register.
  assign out_load = cmd_i.pick | cmd_i.fail;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      node_index_q <= cmd_i.pick ? idx : '0;
      ok_q         <= cmd_i.pick;
      last_q       <= cmd_i.pick ? status_o.job_last : 1'b1;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign node_index_o = node_index_q;
  assign ok_o         = ok_q;
  assign last_o       = last_q;

  // Status to the controller.
  assign status_o.size_zero = (size_q == '0);
  assign status_o.size_big  = (size_q > SIZE_W'(MAX_JOB));
  assign status_o.cnt_last  = (row_q == ROW_W'(ROWS - 1));
  assign status_o.too_few   = (acc_q < CNT_W'(size_q));
  assign status_o.grp_done  = (lp_q >= LP_W'(p_eff));
  assign status_o.node_free = row_eff[idx[COL_W-1:0]];
  assign status_o.job_last  = ((picks_q + SIZE_W'(1)) == size_q);
  assign status_o.out_free  = ~out_valid_q | out_ready_i;

endmodule

`default_nettype wire

### rtl/core/grrna_ctrl.sv
// ----------------------------------------------------------------------------
// grrna_ctrl
// Controller of the node allocator: sequences status updates, the free-node
// count and the round-robin pick scan.
// ----------------------------------------------------------------------------
`default_nettype none

module grrna_ctrl import grrna_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  input  wire logic       op_i,
  output logic            in_ready_o,
  input  wire dp_status_t status_i,
  output dp_cmd_t         cmd_o
);

  ctrl_state_e state_q, state_d;
  logic        accept;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i & in_ready_o;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = (op_i == OP_ALLOC) ? S_DECIDE : S_UPD_RD;
        end
      end
      S_UPD_RD: state_d = S_UPD_WR;
      S_UPD_WR: state_d = S_IDLE;
      S_DECIDE: begin
        if (status_i.size_zero) begin
          state_d = S_IDLE;
        end else if (status_i.size_big) begin
          state_d = S_FAIL;
        end else begin
          state_d = S_CNT_RD;
        end
      end
      S_CNT_RD:  state_d = S_CNT_ACC;
      S_CNT_ACC: state_d = status_i.cnt_last ? S_CNT_CHK : S_CNT_RD;
      S_CNT_CHK: state_d = status_i.too_few ? S_FAIL : S_ENTER;
      S_FAIL: begin
        if (status_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      S_ENTER: state_d = S_PROBE;
      S_PROBE: state_d = status_i.grp_done ? S_ENTER : S_CHECK;
      S_CHECK: begin
        if (!status_i.node_free) begin
          state_d = S_PROBE;
        end else if (status_i.out_free) begin
          state_d = status_i.job_last ? S_IDLE : S_ENTER;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Command outputs.
  always_comb begin
    cmd_o         = '0;
    cmd_o.capture = accept;
    unique case (state_q)
      S_IDLE:    ;
      S_UPD_RD:  cmd_o.upd_rd = 1'b1;
      S_UPD_WR:  cmd_o.upd_wr = 1'b1;
      S_DECIDE:  ;
      S_CNT_RD:  cmd_o.cnt_rd = 1'b1;
      S_CNT_ACC: cmd_o.cnt_acc = 1'b1;
      S_CNT_CHK: cmd_o.scan_init = ~status_i.too_few;
      S_FAIL:    cmd_o.fail = status_i.out_free;
      S_ENTER:   cmd_o.enter = 1'b1;
      S_PROBE:   cmd_o.skip_group = status_i.grp_done;
      S_CHECK: begin
        cmd_o.next_node = ~status_i.node_free;
        cmd_o.pick      = status_i.node_free & status_i.out_free;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

### tb/sv/tb_group_round_robin_node_allocator.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_group_round_robin_node_allocator
// Self-checking testbench for the group round-robin node allocator. A
// scoreboard keeps its own copy of the free map and the two size registers,
// predicts the node indices of every accepted job, and checks each result
// transaction in order. A short directed part covers the corner cases, then
// random phases run with different machine sizes and idling patterns.
// ----------------------------------------------------------------------------

import grrna_pkg::*;

// One expected result transaction.
typedef struct packed {
  logic [NODE_W-1:0] node_index;
  logic              ok;
  logic              last;
} alloc_result_t;

class allocation_scoreboard;
  bit            free_map [NODE_SLOTS];
  int unsigned   num_groups;
  int unsigned   nodes_per_group;
  alloc_result_t expected_picks [$];
  int            errors;

  function new();
    foreach (free_map[i]) free_map[i] = 1'b1;
    num_groups      = MAX_GROUPS;
    nodes_per_group = MAX_GROUP_NODES;
    errors          = 0;
  endfunction

  // A register of zero acts as one, and values above the bound act as the bound.
  function int unsigned clamp_size(int unsigned v, int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function int unsigned machine_nodes();
    int unsigned total;
    total = clamp_size(num_groups, MAX_GROUPS) * clamp_size(nodes_per_group, MAX_GROUP_NODES);
    if (total > NODE_SLOTS) total = NODE_SLOTS;
    return total;
  endfunction

  function void set_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
    if (idx == CFG_NUM_GROUPS) num_groups = 32'(value);
    else if (idx == CFG_NODES_PER_GROUP) nodes_per_group = 32'(value);
  endfunction

  function int pending();
    return expected_picks.size();
  endfunction

  // Notes an accepted request and queues the results that it causes.
  function void note_request(logic op, logic [NODE_W-1:0] node, logic is_free,
                             logic [SIZE_W-1:0] size);
    int unsigned   grp_cnt, grp_nodes, avail, grp, picks, tries, loc, idx;
    bit            found;
    bit            picked [NODE_SLOTS];
    alloc_result_t res;
    if (op == OP_SET) begin
      free_map[node] = is_free;
      return;
    end
    grp_cnt   = clamp_size(num_groups, MAX_GROUPS);
    grp_nodes = clamp_size(nodes_per_group, MAX_GROUP_NODES);
    if (size == 0) return;
    avail = 0;
    for (int i = 0; i < machine_nodes(); i++) avail += 32'(free_map[i]);
    if (size > MAX_JOB || avail < size) begin
      res.node_index = '0;
      res.ok         = 1'b0;
      res.last       = 1'b1;
      expected_picks.push_back(res);
      return;
    end
    foreach (picked[i]) picked[i] = 1'b0;
    grp   = 0;
    picks = 0;
    // Each pick scans one group from local node zero; empty groups pass on.
    while (picks < size) begin
      found = 1'b0;
      for (tries = 0; tries < grp_cnt && !found; tries++) begin
        for (loc = 0; loc < grp_nodes && !found; loc++) begin
          idx = grp * grp_nodes + loc;
          if (idx < NODE_SLOTS && free_map[idx] && !picked[idx]) begin
            picked[idx] = 1'b1;
            picks++;
            res.node_index = idx[NODE_W-1:0];
            res.ok         = 1'b1;
            res.last       = (picks == size);
            expected_picks.push_back(res);
            found = 1'b1;
          end
        end
        grp = (grp + 1 < grp_cnt) ? grp + 1 : 0;
      end
      if (!found) break;
    end
  endfunction

  // Compares one result transaction with the oldest expectation.
  function void check_result(logic [NODE_W-1:0] node_index, logic ok, logic last);
    alloc_result_t want;
    if (expected_picks.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("unexpected result: node_index %0d ok %0d last %0d",
                 node_index, ok, last);
      return;
    end
    want = expected_picks.pop_front();
    if (want.node_index !== node_index || want.ok !== ok || want.last !== last) begin
      errors++;
      if (errors <= 10)
        $display("mismatch: expected node_index %0d ok %0d last %0d, got %0d %0d %0d",
                 want.node_index, want.ok, want.last, node_index, ok, last);
    end
  endfunction
endclass

module tb_group_round_robin_node_allocator;

  localparam int CYCLE_LIMIT  = 2_000_000;
  localparam int SETTLE_WAIT  = 64;
  localparam int PHASE_ITEMS  = 56;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i   = '0;
  logic [CFG_W-1:0]     cfg_data_i  = '0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_ready_o;
  logic                 op_i        = OP_SET;
  logic [NODE_W-1:0]    node_i      = '0;
  logic                 is_free_i   = 1'b0;
  logic [SIZE_W-1:0]    job_size_i  = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [NODE_W-1:0]    node_index_o;
  logic                 ok_o;
  logic                 last_o;

  int sender_idle_pct    = 0;
  int receiver_stall_pct = 0;
  int cycle_count        = 0;

  allocation_scoreboard sb;

  group_round_robin_node_allocator dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .op_i         (op_i),
    .node_i       (node_i),
    .is_free_i    (is_free_i),
    .job_size_i   (job_size_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .node_index_o (node_index_o),
    .ok_o         (ok_o),
    .last_o       (last_o)
  );

  // Clock with an 8 ns period.
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Watchdog on the length of the run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Result side: check each accepted transaction, then pick the next ready.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) sb.check_result(node_index_o, ok_o, last_o);
    end
    out_ready_i <= ($urandom_range(99) >= receiver_stall_pct);
  end

  // Presents one request and holds it until the block takes it.
  task automatic send_request(input logic op, input logic [NODE_W-1:0] node,
                              input logic is_free, input logic [SIZE_W-1:0] size);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i       <= op;
    node_i     <= node;
    is_free_i  <= is_free;
    job_size_i <= size;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(op, node, is_free, size);
  endtask

  // Drains all expected results and lets the block go idle.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0 || !in_ready_o) @(posedge clk_i);
    repeat (SETTLE_WAIT) @(posedge clk_i);
  endtask

  // Writes both size registers, the number of groups first, then the nodes per group.
  task automatic write_config(input logic [CFG_W-1:0] groups, input logic [CFG_W-1:0] nodes);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_NUM_GROUPS;
    cfg_data_i <= groups;
    @(posedge clk_i);
    sb.set_config(CFG_NUM_GROUPS, groups);
    cfg_idx_i  <= CFG_NODES_PER_GROUP;
    cfg_data_i <= nodes;
    @(posedge clk_i);
    sb.set_config(CFG_NODES_PER_GROUP, nodes);
    cfg_we_i   <= 1'b0;
  endtask

  // Random mix of status updates and jobs sized mostly to fit the machine.
  task automatic run_random_phase(input int count);
    int unsigned       machine, job_cap, r;
    logic [NODE_W-1:0] node;
    logic [SIZE_W-1:0] size;
    logic              is_free;
    machine = sb.machine_nodes();
    job_cap = (machine < 16) ? machine : 16;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(99) < 75) node = NODE_W'($urandom_range(machine - 1));
      else node = NODE_W'($urandom_range(255));
      is_free = ($urandom_range(99) < 60);
      r = $urandom_range(99);
      if (r < 5) size = '0;
      else if (r < 10) size = SIZE_W'($urandom_range(127, MAX_JOB + 1));
      else if (r < 30) size = SIZE_W'($urandom_range(MAX_JOB, 1));
      else size = SIZE_W'($urandom_range(job_cap, 1));
      if ($urandom_range(99) < 45) send_request(OP_SET, node, is_free, size);
      else send_request(OP_ALLOC, node, is_free, size);
    end
  endtask

  initial begin
    sb = new();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part on the reset machine of 16 groups of 16 nodes.
    send_request(OP_ALLOC, 8'd0, 1'b0, 7'd1);
    send_request(OP_ALLOC, 8'd0, 1'b0, 7'd64);
    send_request(OP_ALLOC, 8'd0, 1'b0, 7'd0);
    send_request(OP_ALLOC, 8'd0, 1'b0, 7'd65);
    send_request(OP_ALLOC, 8'hff, 1'b1, 7'h7f);
    send_request(OP_SET, 8'd0, 1'b0, 7'd0);
    send_request(OP_SET, 8'hff, 1'b0, 7'h7f);
    send_request(OP_SET, 8'd17, 1'b0, 7'd0);
    send_request(OP_ALLOC, 8'd0, 1'b0, 7'd16);
    send_request(OP_SET, 8'hff, 1'b1, 7'd0);
    send_request(OP_SET, 8'd0, 1'b1, 7'd0);
    settle();

    // Zero registers act as a single node.
    write_config(5'd0, 5'd0);
    send_request(OP_ALLOC, 8'd0, 1'b0, 7'd1);
    send_request(OP_ALLOC, 8'd0, 1'b0, 7'd2);
    send_request(OP_SET, 8'd0, 1'b0, 7'd0);
    send_request(OP_ALLOC, 8'd0, 1'b0, 7'd1);
    send_request(OP_SET, 8'd0, 1'b1, 7'd0);
    settle();

    // Oversized registers clamp to the full machine.
    write_config(5'd31, 5'd31);
    send_request(OP_ALLOC, 8'd0, 1'b0, 7'd64);
    settle();

    // Three groups of five: nodes outside count for nothing, busy group skipped.
    write_config(5'd3, 5'd5);
    send_request(OP_ALLOC, 8'd0, 1'b0, 7'd15);
    send_request(OP_ALLOC, 8'd0, 1'b0, 7'd16);
    for (int i = 5; i < 10; i++) send_request(OP_SET, i[NODE_W-1:0], 1'b0, 7'd0);
    send_request(OP_ALLOC, 8'd0, 1'b0, 7'd4);
    settle();

    // Random phases over machine sizes and idling patterns.
    for (int phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 77; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 77; end
        default: begin sender_idle_pct = 23; receiver_stall_pct = 23; end
      endcase
      case (phase)
        0: write_config(5'd16, 5'd16);
        1: write_config(5'd1, 5'd16);
        2: write_config(5'd16, 5'd1);
        3: write_config(5'd4, 5'd4);
        5: write_config(5'd0, 5'd31);
        default: write_config(CFG_W'($urandom_range(31)), CFG_W'($urandom_range(31)));
      endcase
      run_random_phase(PHASE_ITEMS);
      settle();
    end

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
